// ===== hdl/spct_pkg.sv =====
// Shared widths, codes and transaction types for the shape pair contact test.
`timescale 1ns / 1ps
`default_nettype none
package spct_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int MAG_W = COORD_WIDTH + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int ROOT_W = MAG_W;
	localparam int EXT_W = COORD_WIDTH + 3;
	localparam int DEPTH_W = 31;
	localparam int NORM_W = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;
	localparam int THR_W = 8;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	localparam logic [1:0] FUNC_CC = 2'd0;
	localparam logic [1:0] FUNC_CB = 2'd1;
	localparam logic [1:0] FUNC_BC = 2'd2;
	localparam logic [1:0] FUNC_BB = 2'd3;

	typedef enum logic [1:0] {MODE_CC, MODE_BC, MODE_BB} mode_t;
	typedef enum logic [1:0] {NORM_PX, NORM_NX, NORM_PY, NORM_NY} norm_t;

	typedef struct packed {
		logic [1:0] func;
		logic signed [COORD_WIDTH-1:0] self_word0;
		logic signed [COORD_WIDTH-1:0] self_word1;
		logic signed [COORD_WIDTH-1:0] self_word2;
		logic signed [COORD_WIDTH-1:0] self_word3;
		logic signed [COORD_WIDTH-1:0] other_word0;
		logic signed [COORD_WIDTH-1:0] other_word1;
		logic signed [COORD_WIDTH-1:0] other_word2;
		logic signed [COORD_WIDTH-1:0] other_word3;
	} item_t;

	typedef struct packed {
		logic hit;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic [DEPTH_W-1:0] depth;
	} result_t;

	typedef struct packed {
		logic hit;
		mode_t mode;
		logic neg;
		norm_t norm;
		logic signed [EXT_W-1:0] fix_depth;
		logic signed [EXT_W-1:0] rad;
		logic dx_neg;
		logic dy_neg;
		logic [MAG_W-1:0] dx_mag;
		logic [MAG_W-1:0] dy_mag;
	} side_t;

	typedef struct packed {
		logic hit;
		logic use_div;
		logic neg;
		norm_t norm;
		logic dx_neg;
		logic dy_neg;
		logic [DEPTH_W-1:0] depth;
	} dside_t;

endpackage
`default_nettype wire

// ===== hdl/spct_front.sv =====
// Front stages: shape decode, offsets, squares and hit test.
`timescale 1ns / 1ps
`default_nettype none
module spct_front import spct_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire item_t           item,
	output logic                 out_valid,
	output logic [SQ_W-1:0]      d2,
	output side_t                side
);

	function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
		return {v[COORD_WIDTH-1], v};
	endfunction

	function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] n;
		n = -v;
		return v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
	endfunction

	// stage 1
	logic  valid_s1;
	item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	// stage 2
	logic signed [COORD_WIDTH-1:0] b0, b1, b2, b3, c0, c1, c2, px, py;
	logic signed [DIFF_W-1:0] bc_dx, bc_dy, fl, fr, ft, fb, cc_dx, cc_dy, cc_rs;
	logic signed [DIFF_W-1:0] ox, oy, sa, sb, ta, tb;
	logic signed [COORD_WIDTH-1:0] mnx, mxx, mny, mxy;
	logic bb_hit, bb_xpos, bb_ypos;

	always_comb begin
		if (item_s1.func == FUNC_CB) begin
			b0 = item_s1.other_word0; b1 = item_s1.other_word1;
			b2 = item_s1.other_word2; b3 = item_s1.other_word3;
			c0 = item_s1.self_word0; c1 = item_s1.self_word1; c2 = item_s1.self_word2;
		end else begin
			b0 = item_s1.self_word0; b1 = item_s1.self_word1;
			b2 = item_s1.self_word2; b3 = item_s1.self_word3;
			c0 = item_s1.other_word0; c1 = item_s1.other_word1; c2 = item_s1.other_word2;
		end
		px = (c0 < b0) ? b0 : ((c0 > b2) ? b2 : c0);
		py = (c1 < b1) ? b1 : ((c1 > b3) ? b3 : c1);
		bc_dx = sx(c0) - sx(px);
		bc_dy = sx(c1) - sx(py);
		fl = sx(c0) - sx(b0);
		fr = sx(b2) - sx(c0);
		ft = sx(c1) - sx(b1);
		fb = sx(b3) - sx(c1);
		cc_dx = sx(item_s1.other_word0) - sx(item_s1.self_word0);
		cc_dy = sx(item_s1.other_word1) - sx(item_s1.self_word1);
		cc_rs = sx(item_s1.self_word2) + sx(item_s1.other_word2);
		bb_hit = !(item_s1.self_word2 < item_s1.other_word0 ||
			item_s1.self_word0 > item_s1.other_word2 ||
			item_s1.self_word3 < item_s1.other_word1 ||
			item_s1.self_word1 > item_s1.other_word3);
		mnx = (item_s1.self_word2 < item_s1.other_word2) ? item_s1.self_word2
			: item_s1.other_word2;
		mxx = (item_s1.self_word0 > item_s1.other_word0) ? item_s1.self_word0
			: item_s1.other_word0;
		mny = (item_s1.self_word3 < item_s1.other_word3) ? item_s1.self_word3
			: item_s1.other_word3;
		mxy = (item_s1.self_word1 > item_s1.other_word1) ? item_s1.self_word1
			: item_s1.other_word1;
		ox = sx(mnx) - sx(mxx);
		oy = sx(mny) - sx(mxy);
		sa = sx(item_s1.self_word0) + sx(item_s1.self_word2);
		sb = sx(item_s1.other_word0) + sx(item_s1.other_word2);
		ta = sx(item_s1.self_word1) + sx(item_s1.self_word3);
		tb = sx(item_s1.other_word1) + sx(item_s1.other_word3);
		bb_xpos = (sb >= sa);
		bb_ypos = (tb >= ta);
	end

	logic valid_s2;
	logic [1:0] func_s2;
	logic signed [DIFF_W-1:0] bc_dx_s2, bc_dy_s2, fl_s2, fr_s2, ft_s2, fb_s2;
	logic signed [DIFF_W-1:0] cc_dx_s2, cc_dy_s2, cc_rs_s2, ox_s2, oy_s2;
	logic signed [COORD_WIDTH-1:0] crad_s2;
	logic bb_hit_s2, bb_xpos_s2, bb_ypos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		func_s2 <= item_s1.func;
		bc_dx_s2 <= bc_dx; bc_dy_s2 <= bc_dy;
		fl_s2 <= fl; fr_s2 <= fr; ft_s2 <= ft; fb_s2 <= fb;
		cc_dx_s2 <= cc_dx; cc_dy_s2 <= cc_dy; cc_rs_s2 <= cc_rs;
		ox_s2 <= ox; oy_s2 <= oy;
		crad_s2 <= c2;
		bb_hit_s2 <= bb_hit; bb_xpos_s2 <= bb_xpos; bb_ypos_s2 <= bb_ypos;
	end

	// stage 3
	mode_t mode;
	logic signed [DIFF_W-1:0] dx, dy, rr, fm, fix;
	norm_t face, norm;

	always_comb begin
		if (func_s2 == FUNC_BB) mode = MODE_BB;
		else if (func_s2 == FUNC_CC) mode = MODE_CC;
		else mode = MODE_BC;
		dx = (mode == MODE_CC) ? cc_dx_s2 : bc_dx_s2;
		dy = (mode == MODE_CC) ? cc_dy_s2 : bc_dy_s2;
		rr = (mode == MODE_CC) ? cc_rs_s2 : sx(crad_s2);
		// shallowest face, ties go left, right, top, bottom
		if (fl_s2 <= fr_s2 && fl_s2 <= ft_s2 && fl_s2 <= fb_s2) begin
			face = NORM_NX; fm = fl_s2;
		end else if (fr_s2 <= ft_s2 && fr_s2 <= fb_s2) begin
			face = NORM_PX; fm = fr_s2;
		end else if (ft_s2 <= fb_s2) begin
			face = NORM_NY; fm = ft_s2;
		end else begin
			face = NORM_PY; fm = fb_s2;
		end
		if (mode == MODE_BB) begin
			if (ox_s2 < oy_s2) begin
				fix = ox_s2;
				norm = bb_xpos_s2 ? NORM_PX : NORM_NX;
			end else begin
				fix = oy_s2;
				norm = bb_ypos_s2 ? NORM_PY : NORM_NY;
			end
		end else begin
			fix = fm;
			norm = face;
		end
	end

	logic valid_s3;
	mode_t mode_s3;
	norm_t norm_s3;
	logic neg_s3, dx_neg_s3, dy_neg_s3, bb_hit_s3;
	logic [MAG_W-1:0] dx_mag_s3, dy_mag_s3, r_mag_s3;
	logic signed [DIFF_W-1:0] fix_s3, rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode;
		norm_s3 <= norm;
		neg_s3 <= (func_s2 == FUNC_CB);
		dx_neg_s3 <= dx[DIFF_W-1];
		dy_neg_s3 <= dy[DIFF_W-1];
		bb_hit_s3 <= bb_hit_s2;
		dx_mag_s3 <= mag(dx);
		dy_mag_s3 <= mag(dy);
		r_mag_s3 <= mag(rr);
		fix_s3 <= fix;
		rad_s3 <= rr;
	end

	// stage 4: squares
	logic valid_s4;
	side_t side_s4;
	logic [SQ_W-1:0] dx2_s4, dy2_s4, r2_s4;
	logic signed [DIFF_W-1:0] fix_s4;
	logic bb_hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		dx2_s4 <= SQ_W'(dx_mag_s3) * SQ_W'(dx_mag_s3);
		dy2_s4 <= SQ_W'(dy_mag_s3) * SQ_W'(dy_mag_s3);
		r2_s4 <= SQ_W'(r_mag_s3) * SQ_W'(r_mag_s3);
		fix_s4 <= fix_s3;
		bb_hit_s4 <= bb_hit_s3;
		side_s4.hit <= 1'b0;
		side_s4.mode <= mode_s3;
		side_s4.neg <= neg_s3;
		side_s4.norm <= norm_s3;
		side_s4.fix_depth <= EXT_W'(fix_s3);
		side_s4.rad <= EXT_W'(rad_s3);
		side_s4.dx_neg <= dx_neg_s3;
		side_s4.dy_neg <= dy_neg_s3;
		side_s4.dx_mag <= dx_mag_s3;
		side_s4.dy_mag <= dy_mag_s3;
	end

	// stage 5: distance square and hit test
	logic [SQ_W-1:0] sum;
	side_t side_n;

	always_comb begin
		sum = dx2_s4 + dy2_s4;
		side_n = side_s4;
		if (side_s4.mode == MODE_BB) begin
			side_n.hit = bb_hit_s4;
			side_n.fix_depth = EXT_W'(fix_s4);
		end else begin
			side_n.hit = (sum <= r2_s4);
			side_n.fix_depth = EXT_W'(fix_s4) + side_s4.rad;
		end
	end

	logic valid_s5;
	logic [SQ_W-1:0] d2_s5;
	side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		d2_s5 <= sum;
		side_s5 <= side_n;
	end

	assign out_valid = valid_s5;
	assign d2 = d2_s5;
	assign side = side_s5;

endmodule
`default_nettype wire

// ===== hdl/spct_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
`timescale 1ns / 1ps
`default_nettype none
module spct_sqrt import spct_pkg::*; #(
	parameter int PAY_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [SQ_W-1:0]  radicand,
	input  wire logic [PAY_W-1:0] in_pay,
	output logic                  out_valid,
	output logic [ROOT_W-1:0]     root,
	output logic [PAY_W-1:0]      out_pay
);

	localparam int REM_W = ROOT_W + 4;

	logic vld [ROOT_W+1];
	logic [REM_W-1:0] rem_a [ROOT_W+1];
	logic [ROOT_W-1:0] root_a [ROOT_W+1];
	logic [SQ_W-1:0] rad_a [ROOT_W+1];
	logic [PAY_W-1:0] pay_a [ROOT_W+1];

	assign vld[0] = in_valid;
	assign rem_a[0] = '0;
	assign root_a[0] = '0;
	assign rad_a[0] = radicand;
	assign pay_a[0] = in_pay;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0] rem_sh, trial;
		logic ge;

		always_comb begin
			rem_sh = {rem_a[k][REM_W-3:0], rad_a[k][SQ_W-1-2*k -: 2]};
			trial = REM_W'({root_a[k], 2'b01});
			ge = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld[k+1] <= 1'b0;
			else vld[k+1] <= vld[k];
		end

		always_ff @(posedge clk) begin
			rem_a[k+1] <= ge ? rem_sh - trial : rem_sh;
			root_a[k+1] <= {root_a[k][ROOT_W-2:0], ge};
			rad_a[k+1] <= rad_a[k];
			pay_a[k+1] <= pay_a[k];
		end
	end

	assign out_valid = vld[ROOT_W];
	assign root = root_a[ROOT_W];
	assign out_pay = pay_a[ROOT_W];

endmodule
`default_nettype wire

// ===== hdl/spct_div.sv =====
// Normal division pipeline, depth saturation and result register.
`timescale 1ns / 1ps
`default_nettype none
module spct_div import spct_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [ROOT_W-1:0] span,
	input  wire side_t             side,
	input  wire logic [THR_W-1:0]  thr,
	output logic                   out_valid,
	output result_t                result
);

	localparam int QW = NORMAL_FRAC_BITS + 2;
	localparam int VW = (QW + 1 > NORM_W) ? QW + 1 : NORM_W;

	// entry stage: coincidence, depth and normal source
	logic coinc;
	logic signed [EXT_W-1:0] dd;
	dside_t ds_n;

	always_comb begin
		coinc = (span == '0) || (span < ROOT_W'(thr));
		unique case (side.mode)
			MODE_BB: dd = side.fix_depth;
			MODE_BC: dd = coinc ? side.fix_depth : side.rad - $signed(EXT_W'(span));
			MODE_CC: dd = side.rad - $signed(EXT_W'(span));
			default: dd = side.fix_depth;
		endcase
		ds_n.hit = side.hit;
		ds_n.use_div = (side.mode != MODE_BB) && !coinc;
		ds_n.neg = side.neg;
		ds_n.norm = (side.mode == MODE_CC) ? NORM_PX : side.norm;
		ds_n.dx_neg = side.dx_neg;
		ds_n.dy_neg = side.dy_neg;
		if (dd[EXT_W-1]) ds_n.depth = '0;
		else if (|dd[EXT_W-2:DEPTH_W]) ds_n.depth = '1;
		else ds_n.depth = dd[DEPTH_W-1:0];
	end

	logic vld [QW+1];
	dside_t ds_a [QW+1];
	logic [ROOT_W-1:0] den_a [QW+1];
	logic [ROOT_W-1:0] rx_a [QW+1];
	logic [ROOT_W-1:0] ry_a [QW+1];
	logic [QW-1:0] qx_a [QW+1];
	logic [QW-1:0] qy_a [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld[0] <= 1'b0;
		else vld[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		ds_a[0] <= ds_n;
		den_a[0] <= span;
		rx_a[0] <= side.dx_mag;
		ry_a[0] <= side.dy_mag;
		qx_a[0] <= '0;
		qy_a[0] <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [ROOT_W:0] inx, iny, dn;
		logic gx, gy;

		always_comb begin
			dn = {1'b0, den_a[k]};
			// first step compares unshifted: the quotient's integer bit
			if (k == 0) begin
				inx = {1'b0, rx_a[k]};
				iny = {1'b0, ry_a[k]};
			end else begin
				inx = {rx_a[k], 1'b0};
				iny = {ry_a[k], 1'b0};
			end
			gx = (inx >= dn);
			gy = (iny >= dn);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld[k+1] <= 1'b0;
			else vld[k+1] <= vld[k];
		end

		always_ff @(posedge clk) begin
			rx_a[k+1] <= ROOT_W'(gx ? inx - dn : inx);
			ry_a[k+1] <= ROOT_W'(gy ? iny - dn : iny);
			qx_a[k+1] <= {qx_a[k][QW-2:0], gx};
			qy_a[k+1] <= {qy_a[k][QW-2:0], gy};
			den_a[k+1] <= den_a[k];
			ds_a[k+1] <= ds_a[k];
		end
	end

	// round half away from zero, sign, pick the source and flip for circle-box
	logic [QW:0] rnx, rny;
	logic signed [VW-1:0] mx, my, one_v, fx, fy, vx, vy;
	dside_t ds_f;
	result_t res_n;

	always_comb begin
		ds_f = ds_a[QW];
		rnx = (QW+1)'(qx_a[QW]) + (QW+1)'(1);
		rny = (QW+1)'(qy_a[QW]) + (QW+1)'(1);
		mx = $signed(VW'(rnx[QW:1]));
		my = $signed(VW'(rny[QW:1]));
		one_v = $signed(VW'(1)) <<< NORMAL_FRAC_BITS;
		fx = '0;
		fy = '0;
		case (ds_f.norm)
			NORM_PX: fx = one_v;
			NORM_NX: fx = -one_v;
			NORM_PY: fy = one_v;
			NORM_NY: fy = -one_v;
			default: fx = one_v;
		endcase
		if (ds_f.use_div) begin
			vx = ds_f.dx_neg ? -mx : mx;
			vy = ds_f.dy_neg ? -my : my;
		end else begin
			vx = fx;
			vy = fy;
		end
		if (ds_f.neg) begin
			vx = -vx;
			vy = -vy;
		end
		res_n.hit = ds_f.hit;
		res_n.normal_x = ds_f.hit ? vx[NORM_W-1:0] : '0;
		res_n.normal_y = ds_f.hit ? vy[NORM_W-1:0] : '0;
		res_n.depth = ds_f.hit ? ds_f.depth : '0;
	end

	logic done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vld[QW];
	end

	always_ff @(posedge clk) begin
		result_q <= res_n;
	end

	assign out_valid = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== hdl/shape_pair_contact_test.sv =====
// Top level of the shape pair contact test pipeline.
//
// Issue a pair by raising start with item set; a transaction is taken on
// every rising edge where start is high and busy is low. busy never rises,
// so a new pair may enter on every cycle: one result per cycle sustained.
// Each result appears on result for exactly one cycle with done high.
// The pipeline is the five front stages (decode, offsets, squares, hit test),
// one stage per root bit of the 33-bit square root, and NORMAL_FRAC_BITS + 4
// stages of the normal divider with its entry and output registers.
// Results leave in issue order. The receiver cannot stall: done is a strobe
// and the result must be taken in that cycle.
// cfg_we with cfg_wdata writes coincident_threshold; write it only while no
// transaction is in flight. Reset clears every valid bit, so nothing in
// flight survives, and sets the threshold to one.
`timescale 1ns / 1ps
`default_nettype none
module shape_pair_contact_test import spct_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire item_t            item,
	output logic                  done,
	output result_t               result,
	input  wire logic             cfg_we,
	input  wire logic [THR_W-1:0] cfg_wdata
);

	localparam int LAT = 5 + ROOT_W + NORMAL_FRAC_BITS + 4;

	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	assign busy = 1'b0;

	logic fr_valid;
	logic [SQ_W-1:0] fr_d2;
	side_t fr_side;

	spct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.item      (item),
		.out_valid (fr_valid),
		.d2        (fr_d2),
		.side      (fr_side)
	);

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	logic [$bits(side_t)-1:0] sq_pay;

	spct_sqrt #(.PAY_W($bits(side_t))) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.radicand  (fr_d2),
		.in_pay    (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_pay   (sq_pay)
	);

	spct_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.span      (sq_root),
		.side      (side_t'(sq_pay)),
		.thr       (thr_q),
		.out_valid (done),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("result strobe missing after issue");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result strobe without issue");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.normal_x == '0 && result.normal_y == '0
		&& result.depth == '0)) else $error("miss result not cleared");
`endif

endmodule
`default_nettype wire
